### rtl/core/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared widths, reset values and controller command type for the LRU page
// replacement block.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int unsigned PAGE_W = 4;  // page number width
  localparam int unsigned FRM_W  = 3;  // frame limit register width
  localparam int unsigned RES_W  = 3;  // resident count width

  localparam logic [FRM_W-1:0] FRAMES_RST = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the referenced page
    logic compare;  // compare the page against the recency list
    logic update;   // reorder the list and register the result
  } cmd_t;

endpackage

### rtl/core/lpr_ctrl.sv
// ----------------------------------------------------------------------------
// lpr_ctrl
// Sequencer: load, compare, update, then strobe the result.
// ----------------------------------------------------------------------------
module lpr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output logic          done_o,
  output lpr_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_e;

  state_e state_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == ST_UPD);
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_CMP;
          end
        end
        ST_CMP:  state_q <= ST_UPD;
        ST_UPD:  state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign cmd_o.load    = start_i && (state_q == ST_IDLE);
  assign cmd_o.compare = (state_q == ST_CMP);
  assign cmd_o.update  = (state_q == ST_UPD);

endmodule

### rtl/core/lpr_datapath.sv
// ----------------------------------------------------------------------------
// lpr_datapath
// Recency list, occupancy count, frame limit register and result registers.
// ----------------------------------------------------------------------------
module lpr_datapath #(
  parameter int unsigned MAX_FRAMES = 4,
  parameter int unsigned PAGE_COUNT = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lpr_pkg::cmd_t              cmd_i,
  input  logic                       cfg_we_i,
  input  logic [lpr_pkg::FRM_W-1:0]  cfg_wdata_i,
  input  logic [lpr_pkg::PAGE_W-1:0] page_number_i,
  output logic                       hit_o,
  output logic                       evict_valid_o,
  output logic [lpr_pkg::PAGE_W-1:0] evicted_page_o,
  output logic [lpr_pkg::RES_W-1:0]  resident_count_o
);

  localparam int unsigned PW = lpr_pkg::PAGE_W;
  localparam int unsigned CW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned WW = (CW > lpr_pkg::FRM_W) ? CW : lpr_pkg::FRM_W;
  localparam int unsigned IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam logic [PW:0] PC_SAT =
    (PAGE_COUNT > (1 << PW)) ? (PW+1)'(1 << PW) : (PW+1)'(PAGE_COUNT);
  localparam logic [WW-1:0] MAX_W = WW'(MAX_FRAMES);

  logic [lpr_pkg::FRM_W-1:0] frames_q;
  logic [CW-1:0]             occ_q, occ_d;
  logic [PW-1:0]             page_q;
  logic [PW-1:0]             entry_q [MAX_FRAMES];
  logic [MAX_FRAMES-1:0]     match_q, match_d;
  logic                      hit_q, evict_q;
  logic [PW-1:0]             evicted_q;
  logic [lpr_pkg::RES_W-1:0] res_q;

  logic [PW:0]           page_mod;
  logic [WW-1:0]         occ_w, frm_w, limit, bound;
  logic                  hit, evict;
  logic [CW-1:0]         tail;
  logic [MAX_FRAMES-1:0] shift_en;

  // Fold the page number into the table range by repeated subtraction.
  always_comb begin
    page_mod = {1'b0, page_number_i};
    for (int k = 0; k < 8; k++) begin
      if (page_mod >= PC_SAT) begin
        page_mod = page_mod - PC_SAT;
      end
    end
  end

  always_comb begin
    occ_w = WW'(occ_q);
    frm_w = WW'(frames_q);
    if (frm_w == '0) begin
      limit = WW'(1);
    end else if (frm_w > MAX_W) begin
      limit = MAX_W;
    end else begin
      limit = frm_w;
    end
    hit   = |match_q;
    evict = !hit && (occ_w >= limit) && (occ_w != '0);
    tail  = occ_q - CW'(1);
    bound = evict ? (occ_w - WW'(1)) : occ_w;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      match_d[i]  = (WW'(i) < occ_w) && (entry_q[i] == page_q);
      shift_en[i] = hit ? (|(match_q >> i)) : (WW'(i) <= bound);
    end
    occ_d = (!hit && !evict) ? (occ_q + CW'(1)) : occ_q;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= lpr_pkg::FRAMES_RST;
      occ_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        frames_q <= cfg_wdata_i;
      end
      if (cmd_i.update) begin
        occ_q <= occ_d;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      page_q <= page_mod[PW-1:0];
    end
    if (cmd_i.compare) begin
      match_q <= match_d;
    end
    if (cmd_i.update) begin
      entry_q[0] <= page_q;
      for (int i = 1; i < MAX_FRAMES; i++) begin
        if (shift_en[i]) begin
          entry_q[i] <= entry_q[i-1];
        end
      end
      hit_q     <= hit;
      evict_q   <= evict;
      evicted_q <= evict ? entry_q[tail[IW-1:0]] : '0;
      res_q     <= lpr_pkg::RES_W'(occ_d);
    end
  end

  assign hit_o            = hit_q;
  assign evict_valid_o    = evict_q;
  assign evicted_page_o   = evicted_q;
  assign resident_count_o = res_q;

endmodule

### rtl/core/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// Least-recently-used page replacement over up to MAX_FRAMES frames.
// ----------------------------------------------------------------------------
//
//  channel   | ports                                        | handshake
//  ----------+----------------------------------------------+-------------------
//  request   | page_number_i                                | start & !busy
//  result    | hit_o, evict_valid_o, evicted_page_o,        | result_valid_o,
//            | resident_count_o                             | one-cycle strobe
//  config    | cfg_wdata_i (frame limit)                    | cfg_we_i
//
//  A reference steps through capture, compare against the recency list
//  and reorder. The result strobes in the cycle after the reorder, in the
//  same cycle the block drops busy, so the next transaction may be taken
//  in the cycle the result strobes, not before. The compare and reorder
//  each work on all frames in parallel. Reset empties the list and loads
//  a frame limit of 4. The receiver cannot stall: each strobe lasts one cycle.
//
module lru_page_replacement #(
  parameter int unsigned MAX_FRAMES = 4,
  parameter int unsigned PAGE_COUNT = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request
  input  logic                       start,
  output logic                       busy,
  input  logic [lpr_pkg::PAGE_W-1:0] page_number_i,
  // result
  output logic                       result_valid_o,
  output logic                       hit_o,
  output logic                       evict_valid_o,
  output logic [lpr_pkg::PAGE_W-1:0] evicted_page_o,
  output logic [lpr_pkg::RES_W-1:0]  resident_count_o,
  // frame limit register
  input  logic                       cfg_we_i,
  input  logic [lpr_pkg::FRM_W-1:0]  cfg_wdata_i
);

  lpr_pkg::cmd_t cmd;

  // Sequence each transaction: capture, compare, update.
  lpr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (result_valid_o),
    .cmd_o   (cmd)
  );

  // Hold the recency list; on a hit advance the page to the front, on a
  // miss drop the tail when the frames are full and insert at the front.
  lpr_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_COUNT (PAGE_COUNT)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .page_number_i    (page_number_i),
    .hit_o            (hit_o),
    .evict_valid_o    (evict_valid_o),
    .evicted_page_o   (evicted_page_o),
    .resident_count_o (resident_count_o)
  );

endmodule

### dv/lru_page_checker.sv
// ----------------------------------------------------------------------------
// lru_page_checker
// Passive scoreboard for the LRU page replacement block. It tracks its own
// recency stack, presence map and frame limit, predicts every reference and
// compares each result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module lru_page_checker #(
  parameter int unsigned MAX_FRAMES = 4,
  parameter int unsigned PAGE_COUNT = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  input  logic                       busy,
  input  logic [lpr_pkg::PAGE_W-1:0] page_number_i,
  input  logic                       result_valid_o,
  input  logic                       hit_o,
  input  logic                       evict_valid_o,
  input  logic [lpr_pkg::PAGE_W-1:0] evicted_page_o,
  input  logic [lpr_pkg::RES_W-1:0]  resident_count_o,
  input  logic                       cfg_we_i,
  input  logic [lpr_pkg::FRM_W-1:0]  cfg_wdata_i,
  output int unsigned                err_count_o,
  output int unsigned                pending_o,
  output int unsigned                results_o,
  output int unsigned                hits_o,
  output int unsigned                evicts_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import lpr_pkg::*;

  typedef struct packed {
    logic              hit;
    logic              evict_valid;
    logic [PAGE_W-1:0] evicted_page;
    logic [RES_W-1:0]  resident_count;
  } page_result_t;

  logic [PAGE_W-1:0]     lru_stack [MAX_FRAMES];
  int unsigned           occupancy;
  logic [PAGE_COUNT-1:0] resident_map;
  logic [FRM_W-1:0]      frame_limit;
  page_result_t          expected_refs [$];

  // Predict one reference and advance the mirrored state.
  function automatic page_result_t predict_reference(input logic [PAGE_W-1:0] page_in);
    page_result_t      res;
    int unsigned       limit;
    int unsigned       pos;
    int unsigned       last;
    logic [PAGE_W-1:0] page;
    res   = '0;
    page  = PAGE_W'(page_in % PAGE_COUNT);
    limit = (frame_limit == 0) ? 1 :
            (frame_limit > MAX_FRAMES) ? MAX_FRAMES : int'(frame_limit);
    pos   = occupancy;
    if (resident_map[page]) begin
      for (int i = 0; i < occupancy && i < MAX_FRAMES; i++) begin
        if (lru_stack[i] == page) begin
          pos = i;
          break;
        end
      end
    end
    if (pos < occupancy) begin
      res.hit = 1'b1;
      last    = pos;
    end else begin
      if (occupancy >= limit && occupancy > 0) begin
        // drop the least recent page, occupancy holds
        last             = (occupancy - 1 > MAX_FRAMES - 1) ? MAX_FRAMES - 1 : occupancy - 1;
        res.evict_valid  = 1'b1;
        res.evicted_page = lru_stack[last];
        resident_map[lru_stack[last] % PAGE_COUNT] = 1'b0;
      end else begin
        last = occupancy;
        occupancy++;
      end
      resident_map[page] = 1'b1;
    end
    if (last > MAX_FRAMES - 1) last = MAX_FRAMES - 1;
    for (int unsigned k = last; k > 0; k--) lru_stack[k] = lru_stack[k-1];
    lru_stack[0]       = page;
    res.resident_count = RES_W'(occupancy);
    return res;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      err_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    page_result_t exp_r;
    if (!rst_ni) begin
      foreach (lru_stack[i]) lru_stack[i] = '0;
      occupancy    = 0;
      resident_map = '0;
      frame_limit  = FRAMES_RST;
      expected_refs.delete();
      err_count_o  = 0;
      pending_o    = 0;
      results_o    = 0;
      hits_o       = 0;
      evicts_o     = 0;
    end else begin
      if (result_valid_o) begin
        if (expected_refs.size() == 0) begin
          $error("result strobe with no outstanding reference");
          err_count_o++;
        end else begin
          exp_r = expected_refs.pop_front();
          check_field("hit", exp_r.hit, hit_o);
          check_field("evict_valid", exp_r.evict_valid, evict_valid_o);
          check_field("evicted_page", exp_r.evicted_page, evicted_page_o);
          check_field("resident_count", exp_r.resident_count, resident_count_o);
          results_o++;
          if (exp_r.hit) hits_o++;
          if (exp_r.evict_valid) evicts_o++;
        end
      end
      if (cfg_we_i) frame_limit = cfg_wdata_i;
      if (start && !busy) expected_refs.push_back(predict_reference(page_number_i));
      pending_o = expected_refs.size();
    end
  end

endmodule

### dv/tb_lru_page_replacement.sv
// ----------------------------------------------------------------------------
// tb_lru_page_replacement
// Stimulus and verdict for the LRU page replacement block. A directed run
// walks the frame limit from one frame upward, back down and up again, then random
// phases reprogram the limit and stream page references with random gaps.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement;
  timeunit 1ns;
  timeprecision 1ps;

  import lpr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;  // far above the slowest legal run
  localparam int unsigned RANDOM_REFS = 430;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               start         = 1'b0;
  logic [PAGE_W-1:0]  page_number_i = '0;
  logic               cfg_we_i      = 1'b0;
  logic [FRM_W-1:0]   cfg_wdata_i   = '0;

  logic               busy;
  logic               result_valid_o;
  logic               hit_o;
  logic               evict_valid_o;
  logic [PAGE_W-1:0]  evicted_page_o;
  logic [RES_W-1:0]   resident_count_o;

  int unsigned        err_count;
  int unsigned        pending;
  int unsigned        results;
  int unsigned        hits;
  int unsigned        evicts;
  int unsigned        cycles     = 0;
  int unsigned        sent       = 0;
  logic [7:0]         limits_hit = '0;  // one bit per frame limit value written

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  lru_page_replacement #(
    .MAX_FRAMES(4),
    .PAGE_COUNT(16)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .page_number_i   (page_number_i),
    .result_valid_o  (result_valid_o),
    .hit_o           (hit_o),
    .evict_valid_o   (evict_valid_o),
    .evicted_page_o  (evicted_page_o),
    .resident_count_o(resident_count_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  lru_page_checker #(
    .MAX_FRAMES(4),
    .PAGE_COUNT(16)
  ) u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .page_number_i   (page_number_i),
    .result_valid_o  (result_valid_o),
    .hit_o           (hit_o),
    .evict_valid_o   (evict_valid_o),
    .evicted_page_o  (evicted_page_o),
    .resident_count_o(resident_count_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .err_count_o     (err_count),
    .pending_o       (pending),
    .results_o       (results),
    .hits_o          (hits),
    .evicts_o        (evicts)
  );

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Present one reference and hold it until the block takes it. Leave start
  // high afterwards so back-to-back transactions need no extra edge.
  task automatic issue_ref(input logic [PAGE_W-1:0] page);
    start         <= 1'b1;
    page_number_i <= page;
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  // Idle the request side for a number of cycles.
  task automatic hold_off(input int unsigned n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Drop start and wait until every predicted result has come back. Poll on
  // the falling edge so the checker's update at the rising edge has settled.
  task automatic drain;
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0 || busy) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Program the frame limit; only called with the block idle.
  task automatic write_limit(input logic [FRM_W-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    limits_hit[value] = 1'b1;
  endtask

  // Mostly short gaps, now and then a long one; burst phases never idle.
  function automatic int unsigned pick_gap(input bit burst);
    int unsigned r;
    if (burst) return 0;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    int unsigned       phase_len;
    int unsigned       span;
    int unsigned       r;
    int unsigned       random_sent;
    bit                burst;
    bit                held;
    logic [PAGE_W-1:0] base;
    logic [PAGE_W-1:0] page;

    // Hold reset, then release it on a rising edge.
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: start with a single frame so later raises fill new frames.
    write_limit(3'd1);
    issue_ref(4'd0);   // cold miss, fills the only frame
    issue_ref(4'd15);  // evicts page 0
    issue_ref(4'd15);  // hit
    write_limit(3'd2);
    issue_ref(4'd5);   // raised limit: fill without eviction
    issue_ref(4'd15);  // hit on the least recent entry
    issue_ref(4'd10);  // evict page 5
    write_limit(3'd4);
    issue_ref(4'd3);
    issue_ref(4'd0);   // all four frames occupied now
    issue_ref(4'd12);  // evict least recent
    issue_ref(4'd3);   // hit in the middle of the stack
    issue_ref(4'd0);
    write_limit(3'd7); // above the frame count, acts as four
    issue_ref(4'd5);
    issue_ref(4'd5);
    write_limit(3'd1); // lowered below occupancy: evict one, count stays
    issue_ref(4'd6);
    issue_ref(4'd6);
    issue_ref(4'd9);
    write_limit(3'd0); // zero acts as one frame
    issue_ref(4'd10);
    issue_ref(4'd10);
    write_limit(3'd5);
    issue_ref(4'd15);
    issue_ref(4'd0);

    // Random phases: reprogram the limit, then stream references drawn
    // mostly from a small window of pages so hits and evictions both occur.
    random_sent = 0;
    held        = 1'b0;
    while (random_sent < RANDOM_REFS) begin
      r = $urandom_range(99);
      if (r < 10)      write_limit(FRM_W'($urandom_range(5, 7)));
      else if (r < 16) write_limit(3'd0);
      else             write_limit(FRM_W'($urandom_range(1, 4)));
      phase_len = $urandom_range(10, 60);
      burst     = ($urandom_range(3) == 0);
      base      = PAGE_W'($urandom);
      span      = $urandom_range(2, 7);
      for (int unsigned n = 0; n < phase_len && random_sent < RANDOM_REFS; n++) begin
        if ($urandom_range(7) == 0) page = PAGE_W'($urandom);
        else                        page = PAGE_W'(base + $urandom_range(span));
        issue_ref(page);
        random_sent++;
        // Hold the sender until the block has answered everything, once
        // early on and then occasionally.
        if ((!held && n == phase_len / 2) || $urandom_range(59) == 0) begin
          drain();
          held = 1'b1;
        end else begin
          hold_off(pick_gap(burst));
        end
      end
    end

    drain();
    repeat (8) @(posedge clk_i);

    $display("Summary: %0d references issued, %0d results checked, %0d hits, %0d evictions",
             sent, results, hits, evicts);
    $display("Summary: frame limit values written (bit per value) = 8'b%b", limits_hit);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### lru_page_replacement.f
rtl/core/lpr_pkg.sv
rtl/core/lpr_ctrl.sv
rtl/core/lpr_datapath.sv
rtl/core/lru_page_replacement.sv
dv/lru_page_checker.sv
dv/tb_lru_page_replacement.sv
